// ----- hdl/ffsx_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsx_pkg
// Shared types and constants for the fixed-length frame sync with XOR check.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsx_pkg;

  localparam int unsigned FRAME_LEN_DEF    = 14;
  localparam int unsigned CHECKSUM_LEN_DEF = 11;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd50;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd52;

  // register select, taken from paddr[2]
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;
  } ffsx_markers_t;

  typedef struct packed {
    logic              frame_ok;
    logic [BYTE_W-1:0] source_addr;
    logic [BYTE_W-1:0] dest_addr;
    logic [BYTE_W-1:0] command_code;
    logic [CNT_W-1:0]  total_frames;
    logic [CNT_W-1:0]  good_frames;
    logic [CNT_W-1:0]  bad_frames;
  } ffsx_result_t;

endpackage

`default_nettype wire

// ----- hdl/ffsx_in_if.sv -----
// ----------------------------------------------------------------------------
// ffsx_in_if
// Received-byte request channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffsx_in_if;
  logic                       valid;
  logic                       ready;
  logic [ffsx_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/ffsx_out_if.sv -----
// ----------------------------------------------------------------------------
// ffsx_out_if
// Frame result request channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffsx_out_if;
  logic                       valid;
  logic                       ready;
  logic                       frame_ok;
  logic [ffsx_pkg::BYTE_W-1:0] source_addr;
  logic [ffsx_pkg::BYTE_W-1:0] dest_addr;
  logic [ffsx_pkg::BYTE_W-1:0] command_code;
  logic [ffsx_pkg::CNT_W-1:0]  total_frames;
  logic [ffsx_pkg::CNT_W-1:0]  good_frames;
  logic [ffsx_pkg::CNT_W-1:0]  bad_frames;

  modport source (output valid, output frame_ok, output source_addr, output dest_addr,
                  output command_code, output total_frames, output good_frames,
                  output bad_frames, input ready);
  modport sink   (input valid, input frame_ok, input source_addr, input dest_addr,
                  input command_code, input total_frames, input good_frames,
                  input bad_frames, output ready);
endinterface

`default_nettype wire

// ----- hdl/ffsx_frame.sv -----
// ----------------------------------------------------------------------------
// ffsx_frame
// Frame tracker: position counter, captured header bytes, running XOR and
// frame counters. Produces one result when the last frame byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsx_frame #(
  parameter int unsigned FRAME_LEN    = ffsx_pkg::FRAME_LEN_DEF,
  parameter int unsigned CHECKSUM_LEN = ffsx_pkg::CHECKSUM_LEN_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          byte_en,
  input  wire [ffsx_pkg::BYTE_W-1:0]   byte_in,
  input  ffsx_pkg::ffsx_markers_t      markers,
  output logic                         res_vld,
  output ffsx_pkg::ffsx_result_t       res
);

  localparam int unsigned PosW    = $clog2(FRAME_LEN);
  localparam int unsigned XorLast = (CHECKSUM_LEN < FRAME_LEN - 2) ? CHECKSUM_LEN
                                                                   : FRAME_LEN - 2;
  localparam logic [PosW-1:0] PosLast = PosW'(FRAME_LEN - 1);
  localparam logic [PosW-1:0] PosChk  = PosW'(FRAME_LEN - 2);
  localparam logic [PosW-1:0] PosXor  = PosW'(XorLast);

  logic [PosW-1:0]             pos_r, pos_nxt;
  logic [ffsx_pkg::BYTE_W-1:0] xor_r, xor_nxt;
  logic [ffsx_pkg::BYTE_W-1:0] byte0_r, src_r, dst_r, cmd_r, chk_r;
  logic [ffsx_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic [ffsx_pkg::CNT_W-1:0]  good_r, good_nxt;
  logic [ffsx_pkg::CNT_W-1:0]  bad_r, bad_nxt;
  logic                        take;
  logic                        last;
  logic                        ok;

  assign take = byte_en && !(pos_r == '0 && byte_in != markers.start_marker);
  assign last = take && (pos_r == PosLast);
  assign ok   = (byte0_r == markers.start_marker) && (byte_in == markers.end_marker)
             && (xor_r == chk_r);

  always_comb begin
    pos_nxt   = pos_r;
    xor_nxt   = xor_r;
    total_nxt = total_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    if (take) begin
      pos_nxt = pos_r + PosW'(1);
      if (pos_r != '0 && pos_r <= PosXor) begin
        xor_nxt = xor_r ^ byte_in;
      end
      if (last) begin
        pos_nxt   = '0;
        xor_nxt   = '0;
        total_nxt = total_r + 1'b1;
        if (ok) begin
          good_nxt = good_r + 1'b1;
        end else begin
          bad_nxt = bad_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      xor_r   <= '0;
      total_r <= '0;
      good_r  <= '0;
      bad_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      xor_r   <= xor_nxt;
      total_r <= total_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // captured frame bytes, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      if (pos_r == PosW'(0)) byte0_r <= byte_in;
      if (pos_r == PosW'(1)) src_r   <= byte_in;
      if (pos_r == PosW'(2)) dst_r   <= byte_in;
      if (pos_r == PosW'(3)) cmd_r   <= byte_in;
      if (pos_r == PosChk)   chk_r   <= byte_in;
    end
  end

  assign res_vld          = last;
  assign res.frame_ok     = ok;
  assign res.source_addr  = src_r;
  assign res.dest_addr    = dst_r;
  assign res.command_code = cmd_r;
  assign res.total_frames = total_nxt;
  assign res.good_frames  = good_nxt;
  assign res.bad_frames   = bad_nxt;

endmodule

`default_nettype wire

// ----- hdl/fixed_frame_sync_xor_check.sv -----
// ----------------------------------------------------------------------------
// fixed_frame_sync_xor_check
// Frame sync over a received byte stream with XOR checksum and frame counters.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : one received byte per request (valid/ready).
//   out_ch  : one result per completed frame (frame_ok, header bytes, counters).
//   cfg_*   : APB write/read of start marker (0x0) and end marker (0x4).
// Bytes are dropped while hunting for the start marker; counting it, FRAME_LEN
// bytes form a frame and the last one yields a result.
// Path: the byte that completes a frame is held in the input register, then
// its result is held in the result register.
// Throughput: one byte per cycle, set by the position/XOR update, unless a result stalls.
// Reset: back to hunting, counters cleared, markers to 50 and 52, no result.
// Stall: a held result stops the pipe; in_ch.ready drops only when both the
// input register and the result register are full and out_ch.ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_frame_sync_xor_check #(
  parameter int unsigned FRAME_LEN    = ffsx_pkg::FRAME_LEN_DEF,
  parameter int unsigned CHECKSUM_LEN = ffsx_pkg::CHECKSUM_LEN_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  ffsx_in_if.sink                      in_ch,
  ffsx_out_if.source                   out_ch,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [ffsx_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire [ffsx_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [ffsx_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  ffsx_pkg::ffsx_markers_t     markers_r;
  logic                        in_vld_r;
  logic [ffsx_pkg::BYTE_W-1:0] in_byte_r;
  logic                        out_vld_r;
  ffsx_pkg::ffsx_result_t      out_r;
  logic                        advance;
  logic                        res_vld;
  ffsx_pkg::ffsx_result_t      res;
  logic                        cfg_wr;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      markers_r.start_marker <= ffsx_pkg::START_MARKER_RST;
      markers_r.end_marker   <= ffsx_pkg::END_MARKER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ffsx_pkg::REG_START_MARKER: markers_r.start_marker <= cfg_pwdata[7:0];
        ffsx_pkg::REG_END_MARKER:   markers_r.end_marker   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      ffsx_pkg::REG_START_MARKER:
        cfg_prdata = ffsx_pkg::APB_DW'(markers_r.start_marker);
      ffsx_pkg::REG_END_MARKER:
        cfg_prdata = ffsx_pkg::APB_DW'(markers_r.end_marker);
      default: cfg_prdata = '0;
    endcase
  end

  // pipe control
  assign advance     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  ffsx_frame #(
    .FRAME_LEN    (FRAME_LEN),
    .CHECKSUM_LEN (CHECKSUM_LEN)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (in_vld_r && advance),
    .byte_in (in_byte_r),
    .markers (markers_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.frame_ok     = out_r.frame_ok;
  assign out_ch.source_addr  = out_r.source_addr;
  assign out_ch.dest_addr    = out_r.dest_addr;
  assign out_ch.command_code = out_r.command_code;
  assign out_ch.total_frames = out_r.total_frames;
  assign out_ch.good_frames  = out_r.good_frames;
  assign out_ch.bad_frames   = out_r.bad_frames;

  // assertions
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.total_frames == out_r.good_frames + out_r.bad_frames))
    else $error("frame counters out of step");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_vld_r && out_vld_r && !out_ch.ready))
    else $error("input blocked without a stalled result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives fixed_frame_sync_xor_check with a byte stream and checks each frame
// result against a cycle-free model of the frame hunter, the running XOR and
// the frame counters. Mostly well-formed frames with random content, some
// corrupted or cut short, plus noise, over several start/end marker settings
// including the extremes, with random idles on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned FRM_LEN = ffsx_pkg::FRAME_LEN_DEF;
  localparam int unsigned CHK_LEN = ffsx_pkg::CHECKSUM_LEN_DEF;
  localparam int unsigned BYTE_W  = ffsx_pkg::BYTE_W;
  localparam int unsigned CNT_W   = ffsx_pkg::CNT_W;
  localparam int unsigned APB_AW  = ffsx_pkg::APB_AW;
  localparam int unsigned APB_DW  = ffsx_pkg::APB_DW;
  localparam logic [APB_AW-1:0] ADDR_START = {ffsx_pkg::REG_START_MARKER, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_END   = {ffsx_pkg::REG_END_MARKER, 2'b00};
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 150;

  // tracks the frame state and the results still owed by the block
  class frame_result_tracker;
    logic [BYTE_W-1:0] start_mk;
    logic [BYTE_W-1:0] end_mk;
    int unsigned       pos;
    logic [BYTE_W-1:0] stored [FRM_LEN];
    logic [BYTE_W-1:0] xor_acc;
    logic [CNT_W-1:0]  n_total;
    logic [CNT_W-1:0]  n_good;
    logic [CNT_W-1:0]  n_bad;
    ffsx_pkg::ffsx_result_t pending_frames[$];
    int                errors;
    int                checked;

    function new();
      start_mk = ffsx_pkg::START_MARKER_RST;
      end_mk   = ffsx_pkg::END_MARKER_RST;
      pos      = 0;
      xor_acc  = '0;
      n_total  = '0;
      n_good   = '0;
      n_bad    = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    // returns 1 when the byte was taken into a frame, 0 when dropped
    function bit take_byte(logic [BYTE_W-1:0] b);
      ffsx_pkg::ffsx_result_t r;
      bit ok;
      if (pos == 0 && b != start_mk) return 0;
      stored[pos] = b;
      if (pos >= 1 && pos <= CHK_LEN && pos < FRM_LEN - 1) xor_acc ^= b;
      pos++;
      if (pos == FRM_LEN) begin
        ok = (stored[0] == start_mk) && (stored[FRM_LEN-1] == end_mk) &&
             (xor_acc == stored[FRM_LEN-2]);
        n_total++;
        if (ok) begin
          n_good++;
        end else begin
          n_bad++;
        end
        r.frame_ok     = ok;
        r.source_addr  = stored[1];
        r.dest_addr    = stored[2];
        r.command_code = stored[3];
        r.total_frames = n_total;
        r.good_frames  = n_good;
        r.bad_frames   = n_bad;
        pending_frames.push_back(r);
        pos     = 0;
        xor_acc = '0;
      end
      return 1;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_frame(ffsx_pkg::ffsx_result_t got);
      ffsx_pkg::ffsx_result_t want;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame result: expected none, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      checked++;
      compare_field("frame_ok", want.frame_ok, got.frame_ok);
      compare_field("source_addr", want.source_addr, got.source_addr);
      compare_field("dest_addr", want.dest_addr, got.dest_addr);
      compare_field("command_code", want.command_code, got.command_code);
      compare_field("total_frames", want.total_frames, got.total_frames);
      compare_field("good_frames", want.good_frames, got.good_frames);
      compare_field("bad_frames", want.bad_frames, got.bad_frames);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  ffsx_in_if  in_if();
  ffsx_out_if out_if();

  fixed_frame_sync_xor_check uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  frame_result_tracker tracker;
  int unsigned frame_items;
  int unsigned bytes_sent;
  int unsigned stall_left;
  bit          quiet;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("fixed_frame_sync_xor_check verification failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    ffsx_pkg::ffsx_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.frame_ok     = out_if.frame_ok;
      got.source_addr  = out_if.source_addr;
      got.dest_addr    = out_if.dest_addr;
      got.command_code = out_if.command_code;
      got.total_frames = out_if.total_frames;
      got.good_frames  = out_if.good_frames;
      got.bad_frames   = out_if.bad_frames;
      tracker.check_frame(got);
    end
  end

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    if (tracker.take_byte(b)) frame_items++;
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] src, input logic [BYTE_W-1:0] dst,
                            input logic [BYTE_W-1:0] cmd, input bit corrupt);
    logic [BYTE_W-1:0] fb [FRM_LEN];
    logic [BYTE_W-1:0] sum;
    int unsigned k;
    fb[0] = tracker.start_mk;
    fb[1] = src;
    fb[2] = dst;
    fb[3] = cmd;
    for (k = 4; k < FRM_LEN - 2; k++) fb[k] = BYTE_W'($urandom_range(0, 255));
    sum = '0;
    for (k = 1; k <= CHK_LEN && k < FRM_LEN - 2; k++) sum ^= fb[k];
    fb[FRM_LEN-2] = sum;
    fb[FRM_LEN-1] = tracker.end_mk;
    if (corrupt) begin
      k = $urandom_range(1, FRM_LEN - 1);
      fb[k] = fb[k] ^ BYTE_W'($urandom_range(1, 255));
    end
    for (k = 0; k < FRM_LEN; k++) send_byte(fb[k]);
  endtask

  // wait until no result is owed and the pipe has emptied
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.pending_frames.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // write a marker register, then read it back
  task automatic set_marker(input logic [APB_AW-1:0] addr, input logic [BYTE_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= APB_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_START) begin
      tracker.start_mk = value;
    end else begin
      tracker.end_mk = value;
    end
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[BYTE_W-1:0] !== value) begin
      $display("%0t: register 0x%0h readback mismatch: expected 0x%0h, actual 0x%0h",
               $time, addr, value, cfg_prdata[BYTE_W-1:0]);
      tracker.errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] new_start;
    logic [BYTE_W-1:0] new_end;
    int unsigned goal;
    int unsigned r;
    int unsigned n;
    int unsigned phase;

    tracker       = new();
    frame_items   = 0;
    bytes_sent    = 0;
    stall_left    = 0;
    quiet         = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // noise while hunting, a clean frame with extreme header bytes,
    // then half a frame that the next marker change lands in
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 8'hFF, 8'h5A, 1'b0);
    send_byte(tracker.start_mk);
    repeat (6) send_byte(BYTE_W'($urandom_range(0, 255)));

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin new_start = 8'hFF; new_end = 8'h00; end
        1: begin new_start = 8'h00; new_end = 8'hFF; end
        2: begin
          new_start = ffsx_pkg::START_MARKER_RST;
          new_end   = ffsx_pkg::END_MARKER_RST;
        end
        3: begin new_start = BYTE_W'($urandom_range(0, 255)); new_end = new_start; end
        default: begin
          new_start = BYTE_W'($urandom_range(0, 255));
          new_end   = BYTE_W'($urandom_range(0, 255));
        end
      endcase
      set_marker(ADDR_START, new_start);
      set_marker(ADDR_END, new_end);
      quiet = (phase == 2);
      goal = frame_items + PHASE_ITEMS;
      while (frame_items < goal) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                     BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end else if (r < 85) begin
          n = $urandom_range(1, 5);
          repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
          send_byte(tracker.start_mk);
          n = $urandom_range(1, FRM_LEN - 2);
          repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
        end
      end
    end

    quiet = 1'b0;
    drain();
    repeat (10) @(negedge clk);

    $display("Checked %0d frame results (%0d good, %0d bad) from %0d bytes",
             tracker.checked, tracker.n_good, tracker.n_bad, bytes_sent);
    $display("over %0d marker settings, with stalls on both channels", PHASES + 1);
    if (tracker.errors == 0 && tracker.pending_frames.size() == 0) begin
      $display("fixed_frame_sync_xor_check verification clean");
    end else begin
      $display("fixed_frame_sync_xor_check verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- fixed_frame_sync_xor_check.f -----
hdl/ffsx_pkg.sv
hdl/ffsx_in_if.sv
hdl/ffsx_out_if.sv
hdl/ffsx_frame.sv
hdl/fixed_frame_sync_xor_check.sv
tb/sv/testbench.sv
